/* sv/rxrb_pkg.sv */
// Shared types, constants and helpers for the receive ring buffer.
`timescale 1ns / 1ps
package rxrb_pkg;

  localparam int unsigned DEPTH     = 4096;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned FREE_W    = $clog2(DEPTH + 1);
  localparam int unsigned LEVEL_W   = 13;
  localparam int unsigned FREE_O_W  = 13;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = LEVEL_W;
  localparam int unsigned CMP_W     = (FREE_W > LEVEL_W) ? FREE_W : LEVEL_W;

  localparam logic [LEVEL_W-1:0] BUSY_RESET    = LEVEL_W'(1024);
  localparam logic [LEVEL_W-1:0] REFRESH_RESET = LEVEL_W'(2048);

  localparam logic [CFG_IDX_W-1:0] REG_BUSY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_READ    = 2'd1,
    ACT_REFRESH = 2'd2
  } action_e;

  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic                read_valid;
    logic                flow_stop;
    logic [FREE_O_W-1:0] free_space;
    logic                overflow;
    logic [COUNT_W-1:0]  bytes_consumed;
  } result_t;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] nxt;
    if (p == PTR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = p + PTR_W'(1);
    end
    return nxt;
  endfunction

endpackage

/* sv/rxrb_store.sv */
// Byte storage of the ring buffer with a registered read port.
`timescale 1ns / 1ps
module rxrb_store (
  input  logic                            clk_i,
  input  rxrb_pkg::mem_req_t              req_i,
  output logic [rxrb_pkg::BYTE_W-1:0]     rdata_o
);

  logic [rxrb_pkg::BYTE_W-1:0] mem [rxrb_pkg::DEPTH];
  logic [rxrb_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rxrb_ctrl.sv */
// Pointer, flow control and level register logic of the ring buffer.
`timescale 1ns / 1ps
module rxrb_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [1:0]                         action_i,
  input  logic [rxrb_pkg::BYTE_W-1:0]        data_byte_i,
  input  logic                               chunk_end_i,
  input  logic                               cfg_we_i,
  input  logic [rxrb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rxrb_pkg::CFG_W-1:0]         cfg_data_i,
  output rxrb_pkg::mem_req_t                 mem_req_o,
  output rxrb_pkg::result_t                  result_d_o
);

  logic [rxrb_pkg::PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic                         wait_q, wait_d;
  logic [rxrb_pkg::COUNT_W-1:0] count_q, count_d;
  logic [rxrb_pkg::LEVEL_W-1:0] busy_q, refresh_q;

  logic [rxrb_pkg::FREE_W-1:0]  free_now, free_after;
  logic                         wrote, popped, ovf;

  // Free slots with the write pointer never allowed to catch up with the read pointer.
  always_comb begin
    if (rp_q <= wp_q) begin
      free_now = rxrb_pkg::FREE_W'(rxrb_pkg::DEPTH) + rxrb_pkg::FREE_W'(rp_q)
                 - rxrb_pkg::FREE_W'(wp_q);
    end else begin
      free_now = rxrb_pkg::FREE_W'(rp_q) - rxrb_pkg::FREE_W'(wp_q);
    end
  end

  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    wait_d     = wait_q;
    count_d    = count_q;
    wrote      = 1'b0;
    popped     = 1'b0;
    ovf        = 1'b0;
    free_after = free_now;
    case (rxrb_pkg::action_e'(action_i))
      rxrb_pkg::ACT_WRITE: begin
        if (free_now <= rxrb_pkg::FREE_W'(1)) begin
          ovf = 1'b1;
        end else begin
          wrote      = 1'b1;
          wp_d       = rxrb_pkg::next_pos(wp_q);
          free_after = free_now - rxrb_pkg::FREE_W'(1);
        end
        if (chunk_end_i && !wait_q &&
            (rxrb_pkg::CMP_W'(free_after) < rxrb_pkg::CMP_W'(busy_q))) begin
          wait_d = 1'b1;
        end
      end
      rxrb_pkg::ACT_READ: begin
        if (rp_q != wp_q) begin
          popped     = 1'b1;
          rp_d       = rxrb_pkg::next_pos(rp_q);
          count_d    = count_q + rxrb_pkg::COUNT_W'(1);
          free_after = free_now + rxrb_pkg::FREE_W'(1);
        end
      end
      rxrb_pkg::ACT_REFRESH: begin
        if (wait_q &&
            (rxrb_pkg::CMP_W'(free_now) > rxrb_pkg::CMP_W'(refresh_q))) begin
          wait_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_req_o.we    = accept_i && wrote;
    mem_req_o.waddr = wp_q;
    mem_req_o.wdata = data_byte_i;
    mem_req_o.re    = accept_i && popped;
    mem_req_o.raddr = rp_q;

    result_d_o.read_valid     = popped;
    result_d_o.flow_stop      = wait_d;
    result_d_o.free_space     = rxrb_pkg::FREE_O_W'(free_after);
    result_d_o.overflow       = ovf;
    result_d_o.bytes_consumed = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      wait_q  <= 1'b0;
      count_q <= '0;
    end else if (accept_i) begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      wait_q  <= wait_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= rxrb_pkg::BUSY_RESET;
      refresh_q <= rxrb_pkg::REFRESH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rxrb_pkg::REG_BUSY:    busy_q    <= cfg_data_i;
        rxrb_pkg::REG_REFRESH: refresh_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/rx_ring_buffer_flow_control.sv */
// Receive ring buffer with hysteresis flow control: top level and result register.
// The result is registered when an item is accepted; the popped byte comes from the
// registered read port of the byte store in the same cycle as the other result fields.
// Throughput: one item per cycle; an item is taken whenever the result register is empty
// or its result is transferred in the same cycle.
// Reset: pointers, flow-stop flag and consumed count clear; levels return to 1024 and 2048.
// The byte store is not cleared; only entries that were written are ever read.
`timescale 1ns / 1ps
module rx_ring_buffer_flow_control (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic [rxrb_pkg::BYTE_W-1:0]         data_byte_i,
  input  logic                                chunk_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rxrb_pkg::BYTE_W-1:0]         read_byte_o,
  output logic                                read_valid_o,
  output logic                                flow_stop_o,
  output logic [rxrb_pkg::FREE_O_W-1:0]       free_space_o,
  output logic                                overflow_o,
  output logic [rxrb_pkg::COUNT_W-1:0]        bytes_consumed_o,
  input  logic                                cfg_we_i,
  input  logic [rxrb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rxrb_pkg::CFG_W-1:0]          cfg_data_i
);

  logic                        accept;
  logic                        out_valid_q;
  rxrb_pkg::mem_req_t          mem_req;
  rxrb_pkg::result_t           res_d, res_q;
  logic [rxrb_pkg::BYTE_W-1:0] rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  rxrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .data_byte_i (data_byte_i),
    .chunk_end_i (chunk_end_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .mem_req_o   (mem_req),
    .result_d_o  (res_d)
  );

  rxrb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  // The read data register only loads on a pop, so mask it for other items.
  assign read_byte_o      = res_q.read_valid ? rdata : '0;
  assign out_valid_o      = out_valid_q;
  assign read_valid_o     = res_q.read_valid;
  assign flow_stop_o      = res_q.flow_stop;
  assign free_space_o     = res_q.free_space;
  assign overflow_o       = res_q.overflow;
  assign bytes_consumed_o = res_q.bytes_consumed;

endmodule
